// ===== design/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types and constants of the HSV color correction pixel unit.
// ----------------------------------------------------------------------------
package hcc_pkg;

   // Fixed point: inner values are Q.24, one = 2^24
   localparam int FRAC = 24;
   localparam int VAL_W = FRAC + 1;
   localparam logic [VAL_W-1:0] ONE     = 25'd16777216;
   localparam logic [VAL_W-1:0] HALF    = 25'd8388608;
   localparam logic [FRAC-1:0]  HUE_MAX = 24'd15099494;
   // 2^24 = 255 * 65793 + 1
   localparam logic [16:0] V_MUL = 17'd65793;

   // Long divider geometry
   localparam int DVD_W      = 36;
   localparam int DSR_W      = 11;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DVD_W / DIV_STEPS;

   // Registers from launch to result: entry stage, divider, six math stages
   localparam int BACK_LAT = 1 + DIV_STAGES + 6;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_SHIFT  = 2'd0,
      CSR_CONTRAST   = 2'd1,
      CSR_BRIGHTNESS = 2'd2,
      CSR_SATURATION = 2'd3
   } csr_index_type;

   localparam logic [15:0] HUE_SHIFT_RST  = 16'd6554;
   localparam logic [15:0] CONTRAST_RST   = 16'd8192;
   localparam logic [15:0] BRIGHTNESS_RST = 16'd819;
   localparam logic [15:0] SATURATION_RST = 16'd5325;

   // Hue sectors of the back conversion
   typedef enum logic [2:0] {
      SEC_RED_GREEN  = 3'd0,
      SEC_GREEN_RED  = 3'd1,
      SEC_GREEN_BLUE = 3'd2,
      SEC_BLUE_GREEN = 3'd3,
      SEC_BLUE_RED   = 3'd4,
      SEC_RED_BLUE   = 3'd5
   } sector_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
      logic       last_pixel_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       last_pixel_out;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] hue_shift;
      logic [15:0]        contrast_gain;
      logic signed [15:0] brightness_offset;
      logic [15:0]        saturation_gain;
   } cfg_type;

   // Classified pixel between front and back
   typedef struct packed {
      req_type     pix;
      logic [7:0]  mx;
      logic [7:0]  delta;
      logic [10:0] num;
      logic        bypass;
   } cls_type;

   // Payload that rides beside the divider and math stages
   typedef struct packed {
      req_type          pix;
      logic             bypass;
      logic [VAL_W-1:0] v;
   } side_type;

endpackage

// ===== design/hsv_color_correction_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_color_correction_pixel_unit
// RGBA pixel color correction in HSV space: hue shift, saturation boost,
// contrast and brightness.
//
//   channel  ports                          beat
//   input    req_push / req_full / req_data one pixel
//   result   rsp_empty / rsp_pop / rsp_data one corrected pixel
//   config   csr_write / csr_index / csr_data one register write
//
// One pixel per clock sustained while results are popped. On its way to the
// result queue a pixel passes an entry stage, the two 36-bit dividers (9 stages
// of 4 quotient bits) and six math stages. Reset is synchronous, active high,
// and clears no table. The back end launches only with a result slot reserved,
// so a stalled result side fills the queues and then raises req_full.
// ----------------------------------------------------------------------------
module hsv_color_correction_pixel_unit
   import hcc_pkg::*;
#(
   parameter int OUT_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);
   localparam int CW = $clog2(OUT_DEPTH+1);

   // Configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_shift         <= HUE_SHIFT_RST;
         cfg_ff.contrast_gain     <= CONTRAST_RST;
         cfg_ff.brightness_offset <= BRIGHTNESS_RST;
         cfg_ff.saturation_gain   <= SATURATION_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_HUE_SHIFT:  cfg_ff.hue_shift         <= csr_data;
            CSR_CONTRAST:   cfg_ff.contrast_gain     <= csr_data;
            CSR_BRIGHTNESS: cfg_ff.brightness_offset <= csr_data;
            CSR_SATURATION: cfg_ff.saturation_gain   <= csr_data;
            default: ;
         endcase
      end
   end

   // Front: classify and queue
   cls_type cls, ent;
   logic    mid_empty;
   logic    launch;
   logic [1:0] mid_count;

   hcc_front u_front (
      .pix (req_data),
      .cls (cls)
   );

   hcc_fifo #(
      .WIDTH ($bits(cls_type)),
      .DEPTH (2)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .pop   (launch),
      .rdata (ent),
      .full  (req_full),
      .empty (mid_empty),
      .count (mid_count)
   );

   // Launch only with a result slot reserved
   logic [CW-1:0] inflight_ff, inflight_in;
   logic [CW-1:0] out_count;
   logic [CW:0]   reserved;
   logic          back_vld;
   logic          out_full;
   rsp_type       back_data;

   assign reserved = {1'b0, out_count} + {1'b0, inflight_ff};
   assign launch   = ~mid_empty && (reserved < (CW+1)'(OUT_DEPTH));

   always_comb begin
      inflight_in = inflight_ff;
      if (launch && !back_vld) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (back_vld && !launch) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   hcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .launch    (launch),
      .ent       (ent),
      .out_valid (back_vld),
      .out_data  (back_data)
   );

   // Result queue
   hcc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (back_vld),
      .wdata (back_data),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .full  (out_full),
      .empty (rsp_empty),
      .count (out_count)
   );

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_vld |-> !out_full)
      else $error("result written into a full queue");

   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved <= (CW+1)'(OUT_DEPTH))
      else $error("more results reserved than queue slots");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      launch |-> ##BACK_LAT back_vld)
      else $error("launched pixel did not leave the back end on time");

   a_mid_bound: assert property (@(posedge clock) disable iff (reset)
      mid_count <= 2'd2)
      else $error("front queue count out of range");

endmodule

// ===== design/hcc_fifo.sv =====
// ----------------------------------------------------------------------------
// hcc_fifo
// Small flop-based queue with occupancy count.
// ----------------------------------------------------------------------------
module hcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/hcc_front.sv =====
// ----------------------------------------------------------------------------
// hcc_front
// Classify a pixel: max, min, spread, hue sector numerator, low-saturation.
// ----------------------------------------------------------------------------
module hcc_front
   import hcc_pkg::*;
(
   input  req_type pix,
   output cls_type cls
);
   logic [7:0] r, g, b, mx, mn, delta;
   logic [11:0] delta10;
   logic signed [12:0] num_raw, num_fix;
   logic [10:0] delta6;

   assign r = pix.red_in;
   assign g = pix.green_in;
   assign b = pix.blue_in;

   // Extremes and spread
   always_comb begin
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
   end

   assign delta   = mx - mn;
   assign delta10 = {delta, 3'b0} + {3'b0, delta, 1'b0};
   assign delta6  = {delta, 2'b0} + {2'b0, delta, 1'b0} + 11'd0;

   // Sector numerator; red wins ties over green, green over blue
   always_comb begin
      if (mx == r) begin
         num_raw = $signed({5'b0, g}) - $signed({5'b0, b});
      end else if (mx == g) begin
         num_raw = $signed({5'b0, b}) - $signed({5'b0, r}) + $signed({4'b0, delta, 1'b0});
      end else begin
         num_raw = $signed({5'b0, r}) - $signed({5'b0, g}) + $signed({3'b0, delta, 2'b0});
      end
      num_fix = (num_raw < 0) ? num_raw + $signed({2'b0, delta6}) : num_raw;
   end

   always_comb begin
      cls.pix    = pix;
      cls.mx     = mx;
      cls.delta  = delta;
      cls.num    = num_fix[10:0];
      cls.bypass = (mx == 8'd0) || (delta10 < {4'b0, mx});
   end

endmodule

// ===== design/hcc_div.sv =====
// ----------------------------------------------------------------------------
// hcc_div
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module hcc_div
   import hcc_pkg::*;
(
   input  logic             clock,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient
);
   logic [DSR_W-1:0] rem_w [DIV_STAGES+1];
   logic [DVD_W-1:0] quo_w [DIV_STAGES+1];
   logic [DVD_W-1:0] dvd_w [DIV_STAGES+1];
   logic [DSR_W-1:0] dsr_w [DIV_STAGES+1];

   logic [DSR_W-1:0] rem_ff [DIV_STAGES];
   logic [DVD_W-1:0] quo_ff [DIV_STAGES];
   logic [DVD_W-1:0] dvd_ff [DIV_STAGES];
   logic [DSR_W-1:0] dsr_ff [DIV_STAGES];

   assign rem_w[0] = '0;
   assign quo_w[0] = '0;
   assign dvd_w[0] = dividend;
   assign dsr_w[0] = divisor;
   assign quotient = quo_w[DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DSR_W-1:0] rem_in;
      logic [DVD_W-1:0] quo_in, dvd_in;

      // Shift in dividend bits, subtract where the divisor fits
      always_comb begin
         logic [DSR_W:0] t;
         rem_in = rem_w[s];
         quo_in = quo_w[s];
         dvd_in = dvd_w[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            t      = {rem_in, dvd_in[DVD_W-1]};
            dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_w[s]}) begin
               t      = t - {1'b0, dsr_w[s]};
               quo_in = {quo_in[DVD_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[DVD_W-2:0], 1'b0};
            end
            rem_in = t[DSR_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         quo_ff[s] <= quo_in;
         dvd_ff[s] <= dvd_in;
         dsr_ff[s] <= dsr_w[s];
      end

      assign rem_w[s+1] = rem_ff[s];
      assign quo_w[s+1] = quo_ff[s];
      assign dvd_w[s+1] = dvd_ff[s];
      assign dsr_w[s+1] = dsr_ff[s];
   end

endmodule

// ===== design/hcc_back.sv =====
// ----------------------------------------------------------------------------
// hcc_back
// Hue and saturation division, hue/saturation adjust, HSV to RGB, contrast,
// brightness and scaling. Free-running pipeline, one pixel per cycle.
// ----------------------------------------------------------------------------
module hcc_back
   import hcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    launch,
   input  cls_type ent,
   output logic    out_valid,
   output rsp_type out_data
);
   // Entry stage: divisor/dividend operands and value
   logic             b0_vld_ff;
   side_type         b0_side_ff;
   logic [23:0]      prod_ff;
   logic [DSR_W-1:0] hdsr_ff;
   logic [10:0]      num_ff;
   logic [7:0]       mx_ff;
   logic [VAL_W-1:0] v_in;

   assign v_in = VAL_W'(ent.mx * V_MUL) + VAL_W'(ent.mx == 8'hFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff <= 1'b0;
      end else begin
         b0_vld_ff <= launch;
      end
   end

   always_ff @(posedge clock) begin
      b0_side_ff.pix    <= ent.pix;
      b0_side_ff.bypass <= ent.bypass;
      b0_side_ff.v      <= v_in;
      prod_ff           <= 24'(ent.delta * cfg.saturation_gain);
      hdsr_ff           <= {ent.delta, 2'b0} + {2'b0, ent.delta, 1'b0} + 11'd0;
      num_ff            <= ent.num;
      mx_ff             <= ent.mx;
   end

   // Hue and saturation dividers
   logic [DVD_W-1:0] hue_q, sat_q;

   hcc_div u_hue_div (
      .clock    (clock),
      .dividend ({1'b0, num_ff, {FRAC{1'b0}}}),
      .divisor  (hdsr_ff),
      .quotient (hue_q)
   );

   hcc_div u_sat_div (
      .clock    (clock),
      .dividend ({prod_ff, 12'b0}),
      .divisor  ({3'b0, mx_ff}),
      .quotient (sat_q)
   );

   // Carry the side payload alongside the dividers
   logic     dv_vld_ff  [DIV_STAGES];
   side_type dv_side_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) dv_vld_ff[i] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= b0_vld_ff;
         for (int i = 1; i < DIV_STAGES; i++) dv_vld_ff[i] <= dv_vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      dv_side_ff[0] <= b0_side_ff;
      for (int i = 1; i < DIV_STAGES; i++) dv_side_ff[i] <= dv_side_ff[i-1];
   end

   side_type dv_side;
   assign dv_side = dv_side_ff[DIV_STAGES-1];

   // M1: shift and limit hue, limit saturation, value times saturation
   logic signed [26:0] hsum;
   logic [FRAC-1:0]    h_lim;
   logic [VAL_W-1:0]   s_lim;
   logic               m1_vld_ff;
   side_type           m1_side_ff;
   logic [FRAC-1:0]    m1_h_ff;
   logic [48:0]        m1_vs_ff;

   assign hsum = $signed({3'b0, hue_q[FRAC-1:0]}) + $signed({cfg.hue_shift[15], cfg.hue_shift, 10'b0});

   always_comb begin
      if (hsum < 0 || hsum > $signed({2'b0, ONE})) begin
         h_lim = '0;
      end else if (hsum > $signed({3'b0, HUE_MAX})) begin
         h_lim = HUE_MAX;
      end else begin
         h_lim = hsum[FRAC-1:0];
      end
      if ((|sat_q[DVD_W-1:VAL_W]) || (sat_q[VAL_W-1:0] > ONE)) begin
         s_lim = ONE;
      end else begin
         s_lim = sat_q[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      m1_side_ff <= dv_side;
      m1_h_ff    <= h_lim;
      m1_vs_ff   <= 49'(dv_side.v * s_lim);
   end

   // M2: chroma, sector, ramp operand, offset
   logic [VAL_W-1:0] c2;
   logic [26:0]      hs6;
   logic [2:0]       sec2;
   logic [FRAC-1:0]  frac2;
   logic             m2_vld_ff;
   side_type         m2_side_ff;
   logic [VAL_W-1:0] m2_c_ff, m2_op_ff, m2_m_ff;
   logic [2:0]       m2_sec_ff;

   assign c2    = m1_vs_ff[FRAC +: VAL_W];
   assign hs6   = {1'b0, m1_h_ff, 2'b0} + {2'b0, m1_h_ff, 1'b0};
   assign sec2  = hs6[26:FRAC];
   assign frac2 = hs6[FRAC-1:0];

   always_ff @(posedge clock) begin
      m2_side_ff <= m1_side_ff;
      m2_c_ff    <= c2;
      m2_sec_ff  <= sec2;
      m2_op_ff   <= sec2[0] ? ONE - {1'b0, frac2} : {1'b0, frac2};
      m2_m_ff    <= m1_side_ff.v - c2;
   end

   // M3: ramp product
   logic             m3_vld_ff;
   side_type         m3_side_ff;
   logic [49:0]      m3_x_ff;
   logic [VAL_W-1:0] m3_c_ff, m3_m_ff;
   logic [2:0]       m3_sec_ff;

   always_ff @(posedge clock) begin
      m3_side_ff <= m2_side_ff;
      m3_x_ff    <= m2_c_ff * m2_op_ff;
      m3_c_ff    <= m2_c_ff;
      m3_m_ff    <= m2_m_ff;
      m3_sec_ff  <= m2_sec_ff;
   end

   // M4: place chroma and ramp per sector, add offset
   logic [VAL_W-1:0] x4, r1, g1, b1;
   logic             m4_vld_ff;
   side_type         m4_side_ff;
   logic [VAL_W:0]   m4_ch_ff [3];

   assign x4 = m3_x_ff[FRAC +: VAL_W];

   always_comb begin
      case (sector_type'(m3_sec_ff))
         SEC_RED_GREEN: begin
            r1 = m3_c_ff; g1 = x4;      b1 = '0;
         end
         SEC_GREEN_RED: begin
            r1 = x4;      g1 = m3_c_ff; b1 = '0;
         end
         SEC_GREEN_BLUE: begin
            r1 = '0;      g1 = m3_c_ff; b1 = x4;
         end
         SEC_BLUE_GREEN: begin
            r1 = '0;      g1 = x4;      b1 = m3_c_ff;
         end
         SEC_BLUE_RED: begin
            r1 = x4;      g1 = '0;      b1 = m3_c_ff;
         end
         default: begin
            r1 = m3_c_ff; g1 = '0;      b1 = x4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m4_side_ff  <= m3_side_ff;
      m4_ch_ff[0] <= {1'b0, r1} + {1'b0, m3_m_ff};
      m4_ch_ff[1] <= {1'b0, g1} + {1'b0, m3_m_ff};
      m4_ch_ff[2] <= {1'b0, b1} + {1'b0, m3_m_ff};
   end

   // M5: contrast about mid grey
   logic               m5_vld_ff;
   side_type           m5_side_ff;
   logic signed [44:0] m5_t_ff [3];

   always_ff @(posedge clock) begin
      m5_side_ff <= m4_side_ff;
      for (int i = 0; i < 3; i++) begin
         m5_t_ff[i] <= ($signed({2'b0, m4_ch_ff[i]}) - $signed({3'b0, HALF}))
                       * $signed({1'b0, cfg.contrast_gain});
      end
   end

   // M6: brightness and limit to 0..1
   logic signed [45:0] ysum [3];
   logic               m6_vld_ff;
   side_type           m6_side_ff;
   logic [VAL_W-1:0]   m6_y_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ysum[i] = 46'(m5_t_ff[i] >>> 12) + $signed({21'b0, HALF})
                 + $signed({{20{cfg.brightness_offset[15]}}, cfg.brightness_offset, 10'b0});
      end
   end

   always_ff @(posedge clock) begin
      m6_side_ff <= m5_side_ff;
      for (int i = 0; i < 3; i++) begin
         if (ysum[i] < 0) begin
            m6_y_ff[i] <= '0;
         end else if (ysum[i] > $signed({21'b0, ONE})) begin
            m6_y_ff[i] <= ONE;
         end else begin
            m6_y_ff[i] <= ysum[i][VAL_W-1:0];
         end
      end
   end

   // Valid chain through the math stages
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
         m5_vld_ff <= 1'b0;
         m6_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= dv_vld_ff[DIV_STAGES-1];
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
         m5_vld_ff <= m4_vld_ff;
         m6_vld_ff <= m5_vld_ff;
      end
   end

   // Scale by 255 and truncate; low-saturation pixels keep their color
   logic [32:0] scaled [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scaled[i] = {m6_y_ff[i], 8'b0} - {8'b0, m6_y_ff[i]};
      end
      out_data.alpha_out      = m6_side_ff.pix.alpha_in;
      out_data.last_pixel_out = m6_side_ff.pix.last_pixel_in;
      if (m6_side_ff.bypass) begin
         out_data.red_out   = m6_side_ff.pix.red_in;
         out_data.green_out = m6_side_ff.pix.green_in;
         out_data.blue_out  = m6_side_ff.pix.blue_in;
      end else begin
         out_data.red_out   = scaled[0][31:24];
         out_data.green_out = scaled[1][31:24];
         out_data.blue_out  = scaled[2][31:24];
      end
   end

   assign out_valid = m6_vld_ff;

endmodule

// ===== tb/tb_hsv_color_correction_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_color_correction_pixel_unit
// Self-checking bench for the HSV color correction pixel unit. Pixels are
// pushed through the request queue under random idling, every corrected
// pixel is compared in full against a fixed-point color predictor,
// and the gain, offset and hue registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_hsv_color_correction_pixel_unit;
   import hcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_type              req_data;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_data;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_data;

   // predictor copy of the registers
   logic signed [15:0] hue_reg;
   logic [15:0]        contrast_reg;
   logic signed [15:0] bright_reg;
   logic [15:0]        sat_reg;

   req_type pixel_queue[$];
   rsp_type corrected_queue[$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_off_cycles;
   int      cycle_count;
   int      error_count;
   int      beats_checked;
   int      bypass_count;

   hsv_color_correction_pixel_unit DUT (.*);

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // floor division by 2^k for signed values
   function automatic longint floor_shift(longint x, int k);
      if (x >= 0) return x >>> k;
      return -((-x + (longint'(1) << k) - 1) >>> k);
   endfunction

   function automatic longint limit_unit(longint x);
      if (x < 0) return 0;
      if (x > (longint'(1) << FRAC)) return longint'(1) << FRAC;
      return x;
   endfunction

   // contrast about mid grey, brightness, clamp and scale to 8 bits
   function automatic logic [7:0] grade_channel(longint val);
      longint half;
      longint y;
      half = longint'(1) << (FRAC - 1);
      y = floor_shift((val - half) * longint'(contrast_reg), 12) + half
          + longint'(bright_reg) * 1024;
      y = limit_unit(y);
      return 8'((y * 255) >>> FRAC);
   endfunction

   // full pixel correction
   function automatic rsp_type correct_pixel(req_type p);
      rsp_type o;
      longint  r, g, b, mx, mn, dl, n, h, s, v, c, x, m, hs, fr;
      longint  one, r1, g1, b1;
      int      sec;
      one = longint'(1) << FRAC;
      r = p.red_in;
      g = p.green_in;
      b = p.blue_in;
      o.alpha_out = p.alpha_in;
      o.last_pixel_out = p.last_pixel_in;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      if (mx == 0 || 10 * dl < mx) begin
         o.red_out = p.red_in;
         o.green_out = p.green_in;
         o.blue_out = p.blue_in;
         return o;
      end
      // hue sector numerator, red wins ties over green over blue
      if (mx == r) n = g - b;
      else if (mx == g) n = b - r + 2 * dl;
      else n = r - g + 4 * dl;
      if (n < 0) n += 6 * dl;
      h = (n << FRAC) / (6 * dl);
      h += longint'(hue_reg) * 1024;
      if (h > one) h = one - h;
      if (h < 0) h = 0;
      if (h > longint'(HUE_MAX)) h = longint'(HUE_MAX);
      s = ((dl * longint'(sat_reg)) << 12) / mx;
      if (s > one) s = one;
      v = (mx << FRAC) / 255;
      c = (v * s) >>> FRAC;
      hs = h * 6;
      sec = int'(hs >>> FRAC);
      fr = hs & (one - 1);
      if (sec[0]) x = (c * (one - fr)) >>> FRAC;
      else x = (c * fr) >>> FRAC;
      m = v - c;
      case (sec)
         SEC_RED_GREEN: begin r1 = c; g1 = x; b1 = 0; end
         SEC_GREEN_RED: begin r1 = x; g1 = c; b1 = 0; end
         SEC_GREEN_BLUE: begin r1 = 0; g1 = c; b1 = x; end
         SEC_BLUE_GREEN: begin r1 = 0; g1 = x; b1 = c; end
         SEC_BLUE_RED: begin r1 = x; g1 = 0; b1 = c; end
         default: begin r1 = c; g1 = 0; b1 = x; end
      endcase
      o.red_out = grade_channel(r1 + m);
      o.green_out = grade_channel(g1 + m);
      o.blue_out = grade_channel(b1 + m);
      return o;
   endfunction

   // driver: offer the next pending pixel, advance on accept
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            corrected_queue.push_back(correct_pixel(req_data));
            void'(pixel_queue.pop_front());
         end
         if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_data <= pixel_queue[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // count down the receiver hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
      end
   end

   // monitor: check each popped beat, then choose the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            beats_checked++;
            if (corrected_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected beat %h", rsp_data);
            end else begin
               if (rsp_data !== corrected_queue[0]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected r%0d g%0d b%0d a%0d l%0d, got r%0d g%0d b%0d a%0d l%0d",
                        corrected_queue[0].red_out, corrected_queue[0].green_out,
                        corrected_queue[0].blue_out, corrected_queue[0].alpha_out,
                        corrected_queue[0].last_pixel_out, rsp_data.red_out,
                        rsp_data.green_out, rsp_data.blue_out, rsp_data.alpha_out,
                        rsp_data.last_pixel_out);
               end
               void'(corrected_queue.pop_front());
            end
         end
         if (hold_off_cycles > 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("hsv_color_correction_pixel_unit test failed");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_HUE_SHIFT: hue_reg = val;
         CSR_CONTRAST: contrast_reg = val;
         CSR_BRIGHTNESS: bright_reg = val;
         default: sat_reg = val;
      endcase
      @(posedge clock);
   endtask

   // hold until every pixel has been accepted and every result returned
   task automatic wait_drain();
      while (pixel_queue.size() != 0 || corrected_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic l);
      req_type    p;
      logic [7:0] mx, mn;
      p.red_in = r;
      p.green_in = g;
      p.blue_in = b;
      p.alpha_in = a;
      p.last_pixel_in = l;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx == 8'd0 || 10 * int'(mx - mn) < int'(mx)) bypass_count++;
      pixel_queue.push_back(p);
   endtask

   // a quarter near grey, a quarter red-heavy saturated colors, the rest random
   task automatic add_random(int count);
      logic [7:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         r = 8'($urandom_range(255));
         g = 8'($urandom_range(255));
         b = 8'($urandom_range(255));
         case ($urandom_range(3))
            0: begin
               g = 8'(r - $urandom_range(20));
               b = 8'(r - $urandom_range(20));
            end
            1: begin r = 8'($urandom_range(255, 128)); b = 8'($urandom_range(40)); end
            default: ;
         endcase
         add_pixel(r, g, b, 8'($urandom_range(255)), ($urandom_range(15) == 0));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_HUE_SHIFT;
      csr_data = '0;
      send_idle_pct = 8;
      recv_idle_pct = 64;
      hold_off_cycles = 0;
      cycle_count = 0;
      error_count = 0;
      beats_checked = 0;
      bypass_count = 0;
      hue_reg = HUE_SHIFT_RST;
      contrast_reg = CONTRAST_RST;
      bright_reg = BRIGHTNESS_RST;
      sat_reg = SATURATION_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each hue sector, ties, grey, near threshold
      add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      add_pixel(8'd255, 8'd0, 8'd0, 8'd170, 1'b0);
      add_pixel(8'd255, 8'd128, 8'd0, 8'd85, 1'b0);
      add_pixel(8'd128, 8'd255, 8'd0, 8'd1, 1'b0);
      add_pixel(8'd0, 8'd255, 8'd128, 8'd2, 1'b0);
      add_pixel(8'd0, 8'd128, 8'd255, 8'd4, 1'b0);
      add_pixel(8'd128, 8'd0, 8'd255, 8'd8, 1'b0);
      add_pixel(8'd255, 8'd0, 8'd128, 8'd16, 1'b0);
      add_pixel(8'd200, 8'd200, 8'd10, 8'd32, 1'b0);
      add_pixel(8'd10, 8'd200, 8'd200, 8'd64, 1'b0);
      add_pixel(8'd200, 8'd10, 8'd200, 8'd128, 1'b0);
      add_pixel(8'd100, 8'd91, 8'd91, 8'd0, 1'b0);
      add_pixel(8'd100, 8'd90, 8'd90, 8'd0, 1'b0);
      add_pixel(8'd1, 8'd0, 8'd0, 8'd0, 1'b1);
      add_pixel(8'd0, 8'd0, 8'd1, 8'd0, 1'b0);
      wait_drain();

      // phase 1: registers at extremes, sender mostly busy
      write_reg(CSR_HUE_SHIFT, 16'h7FFF);
      write_reg(CSR_CONTRAST, 16'hFFFF);
      write_reg(CSR_BRIGHTNESS, 16'h8000);
      write_reg(CSR_SATURATION, 16'hFFFF);
      add_random(200);
      wait_drain();
      write_reg(CSR_HUE_SHIFT, 16'h8000);
      write_reg(CSR_CONTRAST, 16'h0000);
      write_reg(CSR_BRIGHTNESS, 16'h7FFF);
      write_reg(CSR_SATURATION, 16'h0000);
      add_random(150);
      wait_drain();

      // phase 2: swap idling, start with a long receiver hold-off
      send_idle_pct = 64;
      recv_idle_pct = 8;
      write_reg(CSR_HUE_SHIFT, 16'd0);
      write_reg(CSR_CONTRAST, 16'd4096);
      write_reg(CSR_BRIGHTNESS, 16'd0);
      write_reg(CSR_SATURATION, 16'd4096);
      send_idle_pct = 0;
      hold_off_cycles = 300;
      add_random(150);
      wait_drain();
      send_idle_pct = 64;
      add_random(300);
      wait_drain();

      // phase 3: no idling, random register values
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 4; k++) begin
         write_reg(CSR_HUE_SHIFT, 16'($urandom));
         write_reg(CSR_CONTRAST, 16'($urandom_range(12000)));
         write_reg(CSR_BRIGHTNESS, 16'($urandom));
         write_reg(CSR_SATURATION, 16'($urandom_range(12000)));
         add_random(200);
         wait_drain();
      end

      $display("checked %0d corrected pixels (%0d low-saturation) over several settings,",
               beats_checked, bypass_count);
      $display("with sender and receiver idling swapped and a full-queue stall");
      if (error_count == 0) begin
         $display("hsv_color_correction_pixel_unit test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("hsv_color_correction_pixel_unit test failed");
      end
      $finish;
   end

endmodule
